[rtl/space_vector_pwm_duty_defines.svh]
// Assertion macros for the space vector PWM duty block
`ifndef SPACE_VECTOR_PWM_DUTY_DEFINES_SVH
`define SPACE_VECTOR_PWM_DUTY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SVPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svpd check failed");

// next-cycle implication
`define SVPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svpd check failed");

`endif

[rtl/svpd_pkg.sv]
// Shared types, constants and lookup functions for the SVPWM duty block
`timescale 1ns / 1ps
package svpd_pkg;

  localparam int unsigned SQ3_Q16  = 113512;
  localparam int unsigned SQ3H_Q16 = 56756;
  localparam int unsigned TIME_MAX = 1048575;
  localparam int unsigned DIV_STAGES = 8;

  localparam logic CFG_BUS    = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  localparam logic [2:0] SECT_NONE_LO = 3'd0;
  localparam logic [2:0] SECT_NONE_HI = 3'd7;

  localparam logic [1:0] SRC_X = 2'd0;
  localparam logic [1:0] SRC_Y = 2'd1;
  localparam logic [1:0] SRC_Z = 2'd2;

  localparam logic [1:0] HALF_A = 2'd0;
  localparam logic [1:0] HALF_B = 2'd1;
  localparam logic [1:0] HALF_C = 2'd2;

  typedef struct packed {
    logic [1:0] src1;
    logic [1:0] src2;
    logic       neg1;
    logic       neg2;
  } tsel_t;

  typedef struct packed {
    logic [1:0] u;
    logic [1:0] v;
    logic [1:0] w;
  } route_t;

  typedef struct packed {
    logic [2:0]         code;
    logic [15:0]        ts;
    logic signed [33:0] t1;
    logic signed [33:0] t2;
    logic [19:0]        at1;
    logic [19:0]        at2;
    logic               over;
    logic [33:0]        dsr;
  } item_t;

  function automatic tsel_t tsel_of(input logic [2:0] code);
    tsel_t s;
    s = '{src1: SRC_X, src2: SRC_X, neg1: 1'b0, neg2: 1'b0};
    case (code)
      3'd1: s = '{src1: SRC_Z, src2: SRC_Y, neg1: 1'b0, neg2: 1'b0};
      3'd2: s = '{src1: SRC_Y, src2: SRC_X, neg1: 1'b0, neg2: 1'b1};
      3'd3: s = '{src1: SRC_Z, src2: SRC_X, neg1: 1'b1, neg2: 1'b0};
      3'd4: s = '{src1: SRC_X, src2: SRC_Z, neg1: 1'b1, neg2: 1'b0};
      3'd5: s = '{src1: SRC_X, src2: SRC_Y, neg1: 1'b0, neg2: 1'b1};
      3'd6: s = '{src1: SRC_Y, src2: SRC_Z, neg1: 1'b1, neg2: 1'b1};
      default: s = '{src1: SRC_X, src2: SRC_X, neg1: 1'b0, neg2: 1'b0};
    endcase
    return s;
  endfunction

  function automatic route_t route_of(input logic [2:0] code);
    route_t r;
    r = '{u: HALF_A, v: HALF_A, w: HALF_A};
    case (code)
      3'd1: r = '{u: HALF_B, v: HALF_A, w: HALF_C};
      3'd2: r = '{u: HALF_A, v: HALF_C, w: HALF_B};
      3'd3: r = '{u: HALF_A, v: HALF_B, w: HALF_C};
      3'd4: r = '{u: HALF_C, v: HALF_B, w: HALF_A};
      3'd5: r = '{u: HALF_C, v: HALF_A, w: HALF_B};
      3'd6: r = '{u: HALF_B, v: HALF_C, w: HALF_A};
      default: r = '{u: HALF_A, v: HALF_A, w: HALF_A};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] mag34(input logic signed [33:0] v);
    logic signed [33:0] n;
    n = -v;
    return v[33] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic [19:0] clamp_time(input logic signed [33:0] v);
    logic [19:0] r;
    if (v[33]) r = '0;
    else if (v > 34'sd1048575) r = 20'(TIME_MAX);
    else r = v[19:0];
    return r;
  endfunction

  function automatic logic [15:0] clamp16(input logic signed [35:0] v);
    logic [15:0] r;
    if (v[35]) r = '0;
    else if (v > 36'sd65535) r = 16'hFFFF;
    else r = v[15:0];
    return r;
  endfunction

  // two restoring steps of the ratio division: {remainder, quotient bits}
  function automatic logic [35:0] div2(input logic [33:0] rem, input logic [33:0] d);
    logic [34:0] r2;
    logic [33:0] r;
    logic [1:0]  q;
    r = rem;
    for (int i = 1; i >= 0; i--) begin
      r2 = {r, 1'b0};
      q[i] = (r2 >= {1'b0, d});
      r = q[i] ? 34'(r2 - {1'b0, d}) : r2[33:0];
    end
    return {r, q};
  endfunction

endpackage

[rtl/space_vector_pwm_duty.sv]
// Top level of the seven-segment space vector PWM duty calculator
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  in_tdata: alpha, beta
//  out_     out  out_tvalid/out_tready out_tdata: compares, sector, active times
//  cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// Sixteen register stages; one item a cycle while the output is not stalled and the scale divider is idle.
// The ratio divider (8 stages, 2 bits each) sets the depth.
// After reset and after each config write the scale divider runs with in_tready low.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "space_vector_pwm_duty_defines.svh"
module space_vector_pwm_duty (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // alpha[15:0], beta[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  // compare_u[15:0], compare_v[31:16], compare_w[47:32], sector_code[50:48],
  // active_time_first[70:51], active_time_second[90:71], zero pad
  output logic [95:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import svpd_pkg::*;

  logic [14:0] bus_r;
  logic [15:0] per_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= 15'd24000;
      per_r <= 16'd4200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUS:    bus_r <= cfg_wdata[14:0];
        CFG_PERIOD: per_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  logic        busy;
  logic [32:0] temp;

  svpd_tdiv u_tdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we),
    .bus   (bus_r),
    .per   (per_r),
    .busy  (busy),
    .temp  (temp)
  );

  logic  adv;
  logic  p_v, d_v;
  item_t p_item, d_item;
  logic [15:0] ratio;
  logic [15:0] cu, cv, cw;
  logic [2:0]  code;
  logic [19:0] at1, at2;

  assign adv       = ~out_tvalid | out_tready;
  assign in_tready = adv & ~busy;

  svpd_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid & ~busy),
    .alpha     (in_tdata[15:0]),
    .beta      (in_tdata[31:16]),
    .ts        (per_r),
    .temp      (temp),
    .out_valid (p_v),
    .out_item  (p_item)
  );

  svpd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p_v),
    .in_item   (p_item),
    .out_valid (d_v),
    .out_item  (d_item),
    .ratio     (ratio)
  );

  svpd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (d_v),
    .in_item   (d_item),
    .ratio     (ratio),
    .out_valid (out_tvalid),
    .cmp_u     (cu),
    .cmp_v     (cv),
    .cmp_w     (cw),
    .code      (code),
    .at1       (at1),
    .at2       (at2)
  );

  assign out_tdata = {5'd0, at2, at1, code, cw, cv, cu};

  `SVPD_ASSERT_NOW(a_busy_blocks, busy, !in_tready)
  `SVPD_ASSERT_NEXT(a_cfg_restarts, cfg_we, busy)
  `SVPD_ASSERT_NOW(a_none_zero_times,
    out_tvalid && (code == SECT_NONE_LO || code == SECT_NONE_HI), at1 == '0 && at2 == '0)
endmodule

[rtl/svpd_tdiv.sv]
// Iterative divider for the timing scale sqrt3*period/bus, rerun after each config change
`timescale 1ns / 1ps
module svpd_tdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [14:0] bus,
  input  logic [15:0] per,
  output logic        busy,
  output logic [32:0] temp
);
  import svpd_pkg::*;

  logic        start_r, run_r;
  logic [5:0]  cnt_r;
  logic [32:0] nq_r;
  logic [14:0] rem_r;
  logic [14:0] dsr;
  logic [15:0] rem_sh;
  logic        ge;
  logic [32:0] num;

  assign dsr    = (bus == '0) ? 15'd1 : bus;
  assign num    = 33'(17'(SQ3_Q16) * per);
  assign rem_sh = {rem_r, nq_r[32]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      run_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (start) begin
      start_r <= 1'b1;
      run_r   <= 1'b0;
    end else if (start_r) begin
      start_r <= 1'b0;
      run_r   <= 1'b1;
      cnt_r   <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd32) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      nq_r  <= num;
      rem_r <= '0;
    end else if (run_r) begin
      nq_r  <= {nq_r[31:0], ge};
      rem_r <= ge ? 15'(rem_sh - {1'b0, dsr}) : rem_sh[14:0];
    end
  end

  assign busy = start_r | run_r;
  assign temp = nq_r;
endmodule

[rtl/svpd_proj.sv]
// Sector code, projections, active times and overmodulation test (five stages)
`timescale 1ns / 1ps
module svpd_proj (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [15:0] alpha,
  input  logic signed [15:0] beta,
  input  logic [15:0]        ts,
  input  logic [32:0]        temp,
  output logic               out_valid,
  output svpd_pkg::item_t    out_item
);
  import svpd_pkg::*;

  localparam logic signed [16:0] SQ3H_S = 17'(SQ3H_Q16);

  // stage A
  logic               a_v_r;
  logic signed [32:0] a_pa_r, a_pa_nxt;
  logic signed [15:0] a_be_r;
  logic [15:0]        a_ts_r;

  assign a_pa_nxt = 33'(SQ3H_S) * 33'(alpha);

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_pa_r <= a_pa_nxt;
      a_be_r <= beta;
      a_ts_r <= ts;
    end
  end

  // stage B
  logic signed [33:0] pa34, bh, px, py, pz, cb, cc;
  logic [2:0]         b_code_nxt;
  logic               b_v_r;
  logic [2:0]         b_code_r;
  logic [15:0]        b_ts_r;
  logic [31:0]        b_m_r [3];
  logic [2:0]         b_s_r;

  assign pa34 = {a_pa_r[32], a_pa_r};
  assign bh   = {{3{a_be_r[15]}}, a_be_r, 15'd0};
  assign px   = {{2{a_be_r[15]}}, a_be_r, 16'd0};
  assign py   = pa34 + bh;
  assign pz   = bh - pa34;
  assign cb   = pa34 - bh;
  assign cc   = -pa34 - bh;
  assign b_code_nxt = {cc > 34'sd0, cb > 34'sd0, a_be_r > 16'sd0};

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_code_r <= b_code_nxt;
      b_ts_r   <= a_ts_r;
      b_m_r[0] <= mag34(px);
      b_m_r[1] <= mag34(py);
      b_m_r[2] <= mag34(pz);
      b_s_r    <= {pz[33], py[33], px[33]};
    end
  end

  // stage C: partial products
  logic        c_v_r;
  logic [2:0]  c_code_r;
  logic [15:0] c_ts_r;
  logic [2:0]  c_s_r;
  logic [48:0] c_lo_r [3];
  logic [48:0] c_hi_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_code_r <= b_code_r;
      c_ts_r   <= b_ts_r;
      c_s_r    <= b_s_r;
      for (int k = 0; k < 3; k++) begin
        c_lo_r[k] <= 49'(temp * b_m_r[k][15:0]);
        c_hi_r[k] <= 49'(temp * b_m_r[k][31:16]);
      end
    end
  end

  // stage D: sum, saturate, sign
  logic               d_v_r;
  logic [2:0]         d_code_r;
  logic [15:0]        d_ts_r;
  logic signed [32:0] d_xyz_r [3];
  logic [64:0]        full [3];
  logic [31:0]        hi32 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      full[k] = 65'(c_lo_r[k]) + {c_hi_r[k], 16'd0};
      hi32[k] = full[k][64] ? 32'hFFFF_FFFF : full[k][63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= c_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_code_r <= c_code_r;
      d_ts_r   <= c_ts_r;
      for (int k = 0; k < 3; k++)
        d_xyz_r[k] <= c_s_r[k] ? -$signed({1'b0, hi32[k]}) : $signed({1'b0, hi32[k]});
    end
  end

  // stage E: pick active times
  tsel_t              sel;
  logic signed [33:0] t1, t2;
  logic signed [34:0] sum;
  logic               none;
  logic               e_v_r;
  item_t              e_item_r, e_item_nxt;

  assign sel  = tsel_of(d_code_r);
  assign none = (d_code_r == SECT_NONE_LO) || (d_code_r == SECT_NONE_HI);
  assign t1   = sel.neg1 ? -34'(d_xyz_r[sel.src1]) : 34'(d_xyz_r[sel.src1]);
  assign t2   = sel.neg2 ? -34'(d_xyz_r[sel.src2]) : 34'(d_xyz_r[sel.src2]);
  assign sum  = 35'(t1) + 35'(t2);

  always_comb begin
    e_item_nxt.code = d_code_r;
    e_item_nxt.ts   = d_ts_r;
    e_item_nxt.t1   = t1;
    e_item_nxt.t2   = t2;
    e_item_nxt.at1  = none ? '0 : clamp_time(t1);
    e_item_nxt.at2  = none ? '0 : clamp_time(t2);
    e_item_nxt.over = sum > $signed({19'd0, d_ts_r});
    e_item_nxt.dsr  = sum[33:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= d_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) e_item_r <= e_item_nxt;
  end

  assign out_valid = e_v_r;
  assign out_item  = e_item_r;
endmodule

[rtl/svpd_div.sv]
// Pipelined restoring divider for the overmodulation ratio, two quotient bits a stage
`timescale 1ns / 1ps
module svpd_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  svpd_pkg::item_t in_item,
  output logic            out_valid,
  output svpd_pkg::item_t out_item,
  output logic [15:0]     ratio
);
  import svpd_pkg::*;

  logic [DIV_STAGES-1:0] st_v_r;
  item_t                 st_item_r [DIV_STAGES];
  logic [33:0]           st_rem_r  [DIV_STAGES];
  logic [15:0]           st_q_r    [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic        v_in;
    item_t       it_in;
    logic [33:0] rem_in;
    logic [15:0] q_in;
    logic [35:0] stp;

    if (g == 0) begin : g_first
      assign v_in   = in_valid;
      assign it_in  = in_item;
      assign rem_in = 34'(in_item.ts);
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = st_v_r[g-1];
      assign it_in  = st_item_r[g-1];
      assign rem_in = st_rem_r[g-1];
      assign q_in   = st_q_r[g-1];
    end

    assign stp = div2(rem_in, it_in.dsr);

    always_ff @(posedge clk) begin
      if (!rst_n) st_v_r[g] <= 1'b0;
      else if (adv) st_v_r[g] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_item_r[g] <= it_in;
        st_rem_r[g]  <= stp[35:2];
        st_q_r[g]    <= {q_in[13:0], stp[1:0]};
      end
    end
  end

  assign out_valid = st_v_r[DIV_STAGES-1];
  assign out_item  = st_item_r[DIV_STAGES-1];
  assign ratio     = st_q_r[DIV_STAGES-1];
endmodule

[rtl/svpd_out.sv]
// Time scaling, half sums and phase routing into the output register (three stages)
`timescale 1ns / 1ps
module svpd_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  svpd_pkg::item_t in_item,
  input  logic [15:0]     ratio,
  output logic            out_valid,
  output logic [15:0]     cmp_u,
  output logic [15:0]     cmp_v,
  output logic [15:0]     cmp_w,
  output logic [2:0]      code,
  output logic [19:0]     at1,
  output logic [19:0]     at2
);
  import svpd_pkg::*;

  // stage G: products
  logic               g_v_r;
  item_t              g_item_r;
  logic signed [50:0] g_p1_r, g_p2_r;
  logic signed [16:0] rs;

  assign rs = $signed({1'b0, ratio});

  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (adv) g_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      g_item_r <= in_item;
      g_p1_r   <= in_item.t1 * rs;
      g_p2_r   <= in_item.t2 * rs;
    end
  end

  // stage H: divide by 2^16 toward zero
  logic               h_v_r;
  item_t              h_item_r, h_item_nxt;
  logic signed [50:0] sc1, sc2;

  assign sc1 = (g_p1_r + (g_p1_r[50] ? 51'sd65535 : 51'sd0)) >>> 16;
  assign sc2 = (g_p2_r + (g_p2_r[50] ? 51'sd65535 : 51'sd0)) >>> 16;

  always_comb begin
    h_item_nxt    = g_item_r;
    h_item_nxt.t1 = g_item_r.over ? sc1[33:0] : g_item_r.t1;
    h_item_nxt.t2 = g_item_r.over ? sc2[33:0] : g_item_r.t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (adv) h_v_r <= g_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) h_item_r <= h_item_nxt;
  end

  // stage I: half sums and routing
  logic signed [35:0] ts36, t1e, t2e, s0, s1, s2;
  logic [15:0]        hv [3];
  logic [15:0]        mid;
  route_t             rt;
  logic               none;
  logic               i_v_r;
  logic [15:0]        u_r, v_r, w_r;
  logic [2:0]         code_r;
  logic [19:0]        at1_r, at2_r;

  assign ts36 = $signed({20'd0, h_item_r.ts});
  assign t1e  = 36'(h_item_r.t1);
  assign t2e  = 36'(h_item_r.t2);
  assign s0   = ts36 + t1e + t2e;
  assign s1   = ts36 - t1e + t2e;
  assign s2   = ts36 - t1e - t2e;
  assign hv[0] = clamp16((s0 + $signed({35'd0, s0[35]})) >>> 1);
  assign hv[1] = clamp16((s1 + $signed({35'd0, s1[35]})) >>> 1);
  assign hv[2] = clamp16((s2 + $signed({35'd0, s2[35]})) >>> 1);
  assign mid   = h_item_r.ts >> 1;
  assign rt    = route_of(h_item_r.code);
  assign none  = (h_item_r.code == SECT_NONE_LO) || (h_item_r.code == SECT_NONE_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (adv) i_v_r <= h_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      u_r    <= none ? mid : hv[rt.u];
      v_r    <= none ? mid : hv[rt.v];
      w_r    <= none ? mid : hv[rt.w];
      code_r <= h_item_r.code;
      at1_r  <= h_item_r.at1;
      at2_r  <= h_item_r.at2;
    end
  end

  assign out_valid = i_v_r;
  assign cmp_u = u_r;
  assign cmp_v = v_r;
  assign cmp_w = w_r;
  assign code  = code_r;
  assign at1   = at1_r;
  assign at2   = at2_r;
endmodule

[tb/sv/space_vector_pwm_duty_test.sv]
// Self-checking regression testbench for the space vector PWM duty block
`timescale 1ns / 1ps
module space_vector_pwm_duty_test;
  import svpd_pkg::*;

  // lowest field last, to line up with out_tdata
  typedef struct packed {
    logic [19:0] t_second;
    logic [19:0] t_first;
    logic [2:0]  sector;
    logic [15:0] cmp_w;
    logic [15:0] cmp_v;
    logic [15:0] cmp_u;
  } duty_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  space_vector_pwm_duty dut (.*);

  always #5 clk = ~clk;

  logic [14:0] bus_reg = 15'd24000;
  logic [15:0] period_reg = 16'd4200;
  duty_t       pending_duty[$];
  int          mismatches = 0;
  int          burst_left = 0;

  // per sector: active time sources and negation, then phase routing
  logic [1:0] src_tab[8][2] = '{'{SRC_X, SRC_X}, '{SRC_Z, SRC_Y}, '{SRC_Y, SRC_X},
                                '{SRC_Z, SRC_X}, '{SRC_X, SRC_Z}, '{SRC_X, SRC_Y},
                                '{SRC_Y, SRC_Z}, '{SRC_X, SRC_X}};
  bit         neg_tab[8][2] = '{'{0, 0}, '{0, 0}, '{0, 1}, '{1, 0},
                                '{1, 0}, '{0, 1}, '{1, 1}, '{0, 0}};
  logic [1:0] phase_tab[8][3] = '{'{HALF_A, HALF_A, HALF_A}, '{HALF_B, HALF_A, HALF_C},
                                  '{HALF_A, HALF_C, HALF_B}, '{HALF_A, HALF_B, HALF_C},
                                  '{HALF_C, HALF_B, HALF_A}, '{HALF_C, HALF_A, HALF_B},
                                  '{HALF_B, HALF_C, HALF_A}, '{HALF_A, HALF_A, HALF_A}};

  function automatic longint dwell(longint unsigned scale, longint p);
    longint unsigned mag;
    logic [127:0]    prod;
    longint          r;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    prod = 128'(scale) * 128'(mag);
    if (prod > 128'(64'hFFFF_FFFF_FFFF_FFFF)) prod = 128'(64'hFFFF_FFFF_FFFF_FFFF);
    r = longint'(prod[95:32]);
    return (p < 0) ? -r : r;
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  function automatic duty_t predict_duty(logic signed [15:0] alpha, logic signed [15:0] beta);
    duty_t           d;
    longint          al, be, ts, t1, t2, ratio;
    longint          proj[3];
    longint          half[3];
    longint unsigned udc, scale;
    logic [2:0]      code;
    al = alpha;
    be = beta;
    ts = period_reg;
    udc = (bus_reg != 0) ? bus_reg : 1;
    code = '0;
    if (be > 0) code[0] = 1'b1;
    if (56756 * al - 32768 * be > 0) code[1] = 1'b1;
    if (-56756 * al - 32768 * be > 0) code[2] = 1'b1;
    d.sector = code;
    if (code == SECT_NONE_LO || code == SECT_NONE_HI) begin
      d.cmp_u = 16'(ts / 2);
      d.cmp_v = 16'(ts / 2);
      d.cmp_w = 16'(ts / 2);
      d.t_first = '0;
      d.t_second = '0;
      return d;
    end
    scale = (64'd113512 * longint'(ts)) / udc;
    proj[SRC_X] = dwell(scale, be * 65536);
    proj[SRC_Y] = dwell(scale, 56756 * al + 32768 * be);
    proj[SRC_Z] = dwell(scale, -56756 * al + 32768 * be);
    t1 = proj[src_tab[code][0]];
    if (neg_tab[code][0]) t1 = -t1;
    t2 = proj[src_tab[code][1]];
    if (neg_tab[code][1]) t2 = -t2;
    d.t_first = 20'(clamp_to(t1, TIME_MAX));
    d.t_second = 20'(clamp_to(t2, TIME_MAX));
    if (t1 + t2 > ts) begin
      ratio = (ts * 65536) / (t1 + t2);
      t1 = (t1 * ratio) / 65536;
      t2 = (t2 * ratio) / 65536;
    end
    half[HALF_A] = (ts + t1 + t2) / 2;
    half[HALF_B] = (ts - t1 + t2) / 2;
    half[HALF_C] = (ts - t1 - t2) / 2;
    d.cmp_u = 16'(clamp_to(half[phase_tab[code][0]], 65535));
    d.cmp_v = 16'(clamp_to(half[phase_tab[code][1]], 65535));
    d.cmp_w = 16'(clamp_to(half[phase_tab[code][2]], 65535));
    return d;
  endfunction

  // receiver stall pattern: out_tready follows a randomly redrawn mode (always, mostly or seldom ready)
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      default: out_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk) begin
    duty_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[90:0];
      if (pending_duty.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
      end else begin
        want = pending_duty.pop_front();
        if (got.cmp_u !== want.cmp_u || got.cmp_v !== want.cmp_v ||
            got.cmp_w !== want.cmp_w || got.sector !== want.sector ||
            got.t_first !== want.t_first || got.t_second !== want.t_second) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp u=%0d v=%0d w=%0d s=%0d t1=%0d t2=%0d, ",
                      "got u=%0d v=%0d w=%0d s=%0d t1=%0d t2=%0d"},
                     want.cmp_u, want.cmp_v, want.cmp_w, want.sector, want.t_first,
                     want.t_second, got.cmp_u, got.cmp_v, got.cmp_w, got.sector,
                     got.t_first, got.t_second);
        end
      end
    end
  end

  // called just after a rising edge
  task automatic send_vector(logic signed [15:0] alpha, logic signed [15:0] beta);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {beta, alpha};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_duty.push_back(predict_duty(alpha, beta));
    burst_left--;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_duty.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BUS) bus_reg = val[14:0];
    else period_reg = val;
  endtask

  task automatic test_directed;
    send_vector(16'sd0, 16'sd0);
    send_vector(-16'sd32768, -16'sd32768);
    send_vector(16'sd32767, 16'sd32767);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, 16'sd32767);
    send_vector(16'sd0, 16'sd1);
    send_vector(16'sd0, -16'sd1);
    send_vector(16'sd1, 16'sd0);
    send_vector(-16'sd1, 16'sd0);
    send_vector(16'sd10000, 16'sd3000);
    send_vector(16'sd3000, 16'sd10000);
    send_vector(-16'sd3000, 16'sd10000);
    send_vector(-16'sd10000, 16'sd3000);
    send_vector(-16'sd10000, -16'sd3000);
    send_vector(-16'sd3000, -16'sd10000);
    send_vector(16'sd3000, -16'sd10000);
    send_vector(16'sd10000, -16'sd3000);
    send_vector(16'sd1000, 16'sd1732);
    send_vector(-16'sd1000, 16'sd1732);
    send_vector(16'sd30000, 16'sd20000);
    send_vector(16'sd100, 16'sd50);
  endtask

  task automatic test_random(int count);
    logic signed [15:0] a, b;
    int span;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          a = 16'($urandom);
          b = 16'($urandom);
        end
        5, 6, 7: begin
          span = $urandom_range(1, 16000);
          a = 16'($signed($urandom_range(0, 2 * span)) - span);
          b = 16'($signed($urandom_range(0, 2 * span)) - span);
        end
        default: begin
          a = 16'($urandom);
          case ($urandom_range(0, 3))
            0: b = 16'sd0;
            1: begin b = a; a = 16'sd0; end
            2: b = 16'((32'(a) * 1732) / 1000);
            default: b = 16'(-(32'(a) * 1732) / 1000);
          endcase
        end
      endcase
      send_vector(a, b);
    end
  endtask

  task automatic test_settings;
    logic [15:0] bus_set[8] = '{16'd24000, 16'd1, 16'd32767, 16'd0,
                                16'd32767, 16'd1, 16'd12000, 16'd24000};
    logic [15:0] per_set[8] = '{16'd4200, 16'd65535, 16'd2, 16'd0,
                                16'd65535, 16'd1, 16'd1000, 16'd4200};
    for (int i = 0; i < 8; i++) begin
      drain();
      write_reg(CFG_BUS, bus_set[i]);
      write_reg(CFG_PERIOD, per_set[i]);
      if (i == 2) test_directed();
      test_random(225);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_duty.size() == 0)
      $display("space_vector_pwm_duty regression: pass");
    else
      $display("space_vector_pwm_duty regression: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("space_vector_pwm_duty regression: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/svpd_pkg.sv
rtl/svpd_tdiv.sv
rtl/svpd_proj.sv
rtl/svpd_div.sv
rtl/svpd_out.sv
rtl/space_vector_pwm_duty.sv
tb/sv/space_vector_pwm_duty_test.sv
